### hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console character writer.
// Used by the channel interfaces and every tcw_* module; no dependencies.
package tcw_pkg;

  // Default screen geometry and tab spacing.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STOP       = 8;

  // Fixed payload widths.
  localparam int CHAR_W = 8;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int COLOR_W = 8;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ESCAPE     = 8'h1B;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_TAB        = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_HIGH = 8'd126;

  // Light grey on black.
  localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

  // Word handed from the input stage to the cursor core.
  typedef struct packed {
    logic              take;
    logic [CHAR_W-1:0] char_code;
  } tcw_item_t;

  // One result word.
  typedef struct packed {
    logic              cell_write;
    logic [ADDR_W-1:0] cell_address;
    logic [CELL_W-1:0] cell_word;
    logic [ADDR_W-1:0] cursor_offset;
  } tcw_result_t;

endpackage

### hw/rtl/tcw_if.sv
// Valid/ready channel interfaces for character input and cell/cursor results.
// Depends on tcw_pkg for payload widths.
interface tcw_char_if;
  logic                      valid;
  logic                      ready;
  logic [tcw_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface tcw_cell_if;
  logic                      valid;
  logic                      ready;
  logic                      cell_write;
  logic [tcw_pkg::ADDR_W-1:0] cell_address;
  logic [tcw_pkg::CELL_W-1:0] cell_word;
  logic [tcw_pkg::ADDR_W-1:0] cursor_offset;

  modport source (output valid, output cell_write, output cell_address,
                  output cell_word, output cursor_offset, input ready);
  modport sink   (input valid, input cell_write, input cell_address,
                  input cell_word, input cursor_offset, output ready);
endinterface

### hw/rtl/text_console_char_writer_top.sv
// Top level of the text console character writer.
// Depends on tcw_pkg, tcw_if, tcw_in_stage, tcw_cursor_core and tcw_out_stage.
//
// Takes one character word per cycle unless out_chan backpressure stalls it,
// and drives a text-mode screen of SCREEN_COLUMNS by SCREEN_ROWS cells. ESC
// arms an escape, and the byte after it becomes the color for later cells (no
// result). Newline moves to column 0 of the next row, tab to the next multiple
// of TAB_STOP or to the next row when that stop falls past the last column;
// both give a result with cell_write low and the new cursor_offset. A
// printable byte (32..126) gives a result with cell_write high, the cell at
// the old cursor and the word {color, char}, then advances the cursor. The row
// wraps to 0 at the bottom. Other bytes are dropped without a result.
// Throughput is one word per cycle while out_chan is not stalled. An accepted
// word waits in an input register, the cursor update in tcw_cursor_core runs
// from it, and the result register captures the outcome. The cursor offset is
// kept as a running sum, so no multiplier sits in the update loop. While a
// finished result waits downstream, the input register can still take a new
// word, but that word waits there until the held result is taken.
module text_console_char_writer_top #(
  parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS,
  parameter int TAB_STOP       = tcw_pkg::TAB_STOP
) (
  input logic        clk,
  input logic        rst_n,
  tcw_char_if.sink   in_chan,
  tcw_cell_if.source out_chan
);

  tcw_pkg::tcw_item_t   item;
  tcw_pkg::tcw_result_t core_result;
  tcw_pkg::tcw_result_t held_result;
  logic                 push;
  logic                 advance;

  // Hold the incoming character until the core can consume it.
  tcw_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_char  (in_chan.char_code),
    .advance  (advance),
    .item_o   (item)
  );

  // Decode the character and advance the cursor state.
  tcw_cursor_core #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS),
    .TAB_STOP       (TAB_STOP)
  ) u_cursor_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_i   (item),
    .push_o   (push),
    .result_o (core_result)
  );

  // Register the result; advance stalls the input stage under backpressure.
  tcw_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .result_i  (core_result),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .advance   (advance),
    .result_o  (held_result)
  );

  assign out_chan.cell_write    = held_result.cell_write;
  assign out_chan.cell_address  = held_result.cell_address;
  assign out_chan.cell_word     = held_result.cell_word;
  assign out_chan.cursor_offset = held_result.cursor_offset;

endmodule

### hw/rtl/tcw_in_stage.sv
// Input register of the character writer: holds one character word.
// Depends on tcw_pkg for the item struct.
module tcw_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [tcw_pkg::CHAR_W-1:0]  in_char,
  input  logic                        advance,
  output tcw_pkg::tcw_item_t          item_o
);

  logic                       valid_r, valid_nxt;
  logic [tcw_pkg::CHAR_W-1:0] char_r;
  logic                       load;

  // Take a new word whenever the held one leaves or none is held.
  assign in_ready = !valid_r || advance;
  assign load     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= in_char;
    end
  end

  assign item_o.take      = valid_r && advance;
  assign item_o.char_code = char_r;

endmodule

### hw/rtl/tcw_cursor_core.sv
// Cursor, color and escape state plus the per-character decode.
// Depends on tcw_pkg; fed by tcw_in_stage, feeds tcw_out_stage.
module tcw_cursor_core #(
  parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS,
  parameter int TAB_STOP       = tcw_pkg::TAB_STOP
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tcw_pkg::tcw_item_t   item_i,
  output logic                 push_o,
  output tcw_pkg::tcw_result_t result_o
);

  localparam int CW = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int RW = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
  localparam int OW = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);
  localparam int PW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int SW = $clog2(SCREEN_COLUMNS + TAB_STOP + 1);
  localparam int AW = tcw_pkg::ADDR_W;

  logic [CW-1:0]               col_r, col_nxt;
  logic [RW-1:0]               row_r, row_nxt;
  logic [OW-1:0]               offset_r, offset_nxt;
  logic [PW-1:0]               phase_r, phase_nxt;   // column modulo tab spacing
  logic [tcw_pkg::COLOR_W-1:0] color_r, color_nxt;
  logic                        esc_r, esc_nxt;

  logic                        row_last;
  logic [RW-1:0]               row_wrap;
  logic [OW-1:0]               line_base;
  logic [OW-1:0]               next_line;
  logic [SW-1:0]               col_w;
  logic [SW-1:0]               stop_w;
  logic [SW-1:0]               col_inc_w;
  logic [PW-1:0]               phase_inc;
  logic [OW+AW-1:0]            offset_now_x;
  logic [OW+AW-1:0]            offset_new_x;
  logic [tcw_pkg::CHAR_W-1:0]  ch;

  assign ch        = item_i.char_code;
  assign row_last  = (row_r == RW'(SCREEN_ROWS - 1));
  assign row_wrap  = row_last ? '0 : row_r + 1'b1;
  assign line_base = offset_r - OW'(col_r);
  assign next_line = row_last ? '0 : line_base + OW'(SCREEN_COLUMNS);
  assign col_w     = SW'(col_r);
  assign stop_w    = col_w - SW'(phase_r) + SW'(TAB_STOP);
  assign col_inc_w = col_w + 1'b1;
  assign phase_inc = (phase_r == PW'(TAB_STOP - 1)) ? '0 : phase_r + 1'b1;

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    offset_nxt = offset_r;
    phase_nxt  = phase_r;
    color_nxt  = color_r;
    esc_nxt    = esc_r;
    push_o     = 1'b0;
    result_o   = '0;
    if (item_i.take) begin
      if (esc_r) begin
        // Byte after escape becomes the color, whatever it is.
        color_nxt = ch;
        esc_nxt   = 1'b0;
      end else if (ch == tcw_pkg::CHAR_ESCAPE) begin
        esc_nxt = 1'b1;
      end else if (ch == tcw_pkg::CHAR_NEWLINE) begin
        col_nxt    = '0;
        phase_nxt  = '0;
        row_nxt    = row_wrap;
        offset_nxt = next_line;
        push_o     = 1'b1;
      end else if (ch == tcw_pkg::CHAR_TAB) begin
        phase_nxt = '0;
        push_o    = 1'b1;
        if (stop_w >= SW'(SCREEN_COLUMNS)) begin
          col_nxt    = '0;
          row_nxt    = row_wrap;
          offset_nxt = next_line;
        end else begin
          col_nxt    = stop_w[CW-1:0];
          offset_nxt = line_base + OW'(stop_w);
        end
      end else if (ch inside {[tcw_pkg::CHAR_PRINT_LOW:tcw_pkg::CHAR_PRINT_HIGH]}) begin
        push_o                = 1'b1;
        result_o.cell_write   = 1'b1;
        result_o.cell_address = offset_now_x[AW-1:0];
        result_o.cell_word    = {color_r, ch};
        if (col_inc_w >= SW'(SCREEN_COLUMNS)) begin
          col_nxt    = '0;
          phase_nxt  = '0;
          row_nxt    = row_wrap;
          offset_nxt = next_line;
        end else begin
          col_nxt    = col_inc_w[CW-1:0];
          phase_nxt  = phase_inc;
          offset_nxt = offset_r + 1'b1;
        end
      end
    end
    result_o.cursor_offset = offset_new_x[AW-1:0];
  end

  // Zero-extend before cutting to the address width so the slice is legal for any geometry.
  assign offset_now_x = {{AW{1'b0}}, offset_r};
  assign offset_new_x = {{AW{1'b0}}, offset_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      offset_r <= '0;
      phase_r  <= '0;
      color_r  <= tcw_pkg::RESET_COLOR;
      esc_r    <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      offset_r <= offset_nxt;
      phase_r  <= phase_nxt;
      color_r  <= color_nxt;
      esc_r    <= esc_nxt;
    end
  end

  // The running offset must track row and column exactly.
  a_offset_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    int'(offset_r) == int'(row_r) * SCREEN_COLUMNS + int'(col_r))
    else $error("cursor offset out of step with row and column");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < SCREEN_COLUMNS) && (int'(row_r) < SCREEN_ROWS))
    else $error("cursor outside the screen");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(phase_r) < TAB_STOP || (TAB_STOP == 1 && phase_r == '0))
    else $error("tab phase out of range");

  // The byte after an escape only changes the color.
  a_escape_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (item_i.take && esc_r) |-> (!push_o && offset_nxt == offset_r && !esc_nxt))
    else $error("escape sequence moved the cursor or produced a result");

endmodule

### hw/rtl/tcw_out_stage.sv
// Result register of the character writer: holds one result word.
// Depends on tcw_pkg for the result struct.
module tcw_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  tcw_pkg::tcw_result_t result_i,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 advance,
  output tcw_pkg::tcw_result_t result_o
);

  logic                 valid_r, valid_nxt;
  tcw_pkg::tcw_result_t data_r;

  // Room for a new word when empty or when the held word is taken now.
  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (push_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      data_r <= result_i;
    end
  end

  assign out_valid = valid_r;
  assign result_o  = data_r;

endmodule
